@@ hdl/rbs_pkg.sv @@
// ----------------------------------------------------------------------------
// rbs_pkg
// shared widths, constants and item types for the ray / box slab test
// ----------------------------------------------------------------------------
package rbs_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int SEG_SCALE   = 1000;
    localparam int SCALE_W     = 10;
    localparam int AXES        = 3;
    localparam int LANES       = 2 * AXES;

    // box - origin and dir * scale, both exact
    localparam int NUM_W = COORD_WIDTH + 1;
    localparam int DEN_W = COORD_WIDTH + SCALE_W;

    // slab parameter: 32 fraction bits, saturated at 4.0
    localparam int T_FRAC    = 32;
    localparam int Q_W       = T_FRAC + 2;
    localparam int T_W       = T_FRAC + 4;
    localparam int R_W       = DEN_W + 2;
    localparam int DIV_STEPS = Q_W;
    localparam int ENTER_W   = 17;

    localparam logic signed [T_W-1:0] T_ZERO = '0;
    localparam logic signed [T_W-1:0] T_ONE  = T_W'(1) << T_FRAC;
    localparam logic signed [T_W-1:0] T_SAT  = T_W'(4) << T_FRAC;

    localparam int REQ_DEPTH = 2;
    localparam int REQ_PTR_W = $clog2(REQ_DEPTH);
    localparam int REQ_CNT_W = $clog2(REQ_DEPTH + 1);
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    typedef struct packed {
        t_coord [AXES-1:0] origin;
        t_coord [AXES-1:0] dir;
        t_coord [AXES-1:0] box_min;
        t_coord [AXES-1:0] box_max;
    } t_ray_in;

    typedef struct packed {
        logic [AXES-1:0][NUM_W-1:0] num_lo;
        logic [AXES-1:0][NUM_W-1:0] num_hi;
        logic [AXES-1:0][DEN_W-1:0] den;
        logic [AXES-1:0]            zero;
        logic [AXES-1:0]            org_in;
    } t_slab_req;

    typedef struct packed {
        logic               hit;
        logic [ENTER_W-1:0] enter_param;
    } t_result;

endpackage

@@ hdl/ray_box_slab_intersect.sv @@
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// segment versus axis-aligned box test by the slab method
// ----------------------------------------------------------------------------
// Each item is one test: the segment from the origin to origin + 1000 * dir,
// all Q16.16, against the box [box_min, box_max]. The result item gives hit
// and the entry parameter along the segment in Q1.16 (0 on a miss). One item
// is taken per cycle while full is low, and results leave in order. The
// divider pipeline retires one quotient bit per stage over 34 stages for
// all six slab parameters at once. Both sides are queues: the front register
// stage and a two-entry request queue decouple input from the dividers, a
// four-entry result queue decouples the dividers from the consumer.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input side
    input  logic                              push,
    output logic                              full,
    input  logic signed [rbs_pkg::COORD_WIDTH-1:0] i_origin_x,
    input  logic signed [rbs_pkg::COORD_WIDTH-1:0] i_origin_y,
    input  logic signed [rbs_pkg::COORD_WIDTH-1:0] i_origin_z,
    input  logic signed [rbs_pkg::COORD_WIDTH-1:0] i_dir_x,
    input  logic signed [rbs_pkg::COORD_WIDTH-1:0] i_dir_y,
    input  logic signed [rbs_pkg::COORD_WIDTH-1:0] i_dir_z,
    input  logic signed [rbs_pkg::COORD_WIDTH-1:0] i_box_min_x,
    input  logic signed [rbs_pkg::COORD_WIDTH-1:0] i_box_min_y,
    input  logic signed [rbs_pkg::COORD_WIDTH-1:0] i_box_min_z,
    input  logic signed [rbs_pkg::COORD_WIDTH-1:0] i_box_max_x,
    input  logic signed [rbs_pkg::COORD_WIDTH-1:0] i_box_max_y,
    input  logic signed [rbs_pkg::COORD_WIDTH-1:0] i_box_max_z,
    // result side
    output logic                              empty,
    input  logic                              pop,
    output logic                              o_hit,
    output logic [rbs_pkg::ENTER_W-1:0]       o_enter_param
);

    rbs_pkg::t_ray_in   item;
    rbs_pkg::t_slab_req fr_req;
    rbs_pkg::t_slab_req q_req;
    rbs_pkg::t_result   bk_res;
    rbs_pkg::t_result   out_res;
    logic               fr_push;
    logic               req_full;
    logic               req_empty;
    logic               req_pop;
    logic               res_full;
    logic               res_push;

    // gather the ports into axis-indexed vectors (x = 0, y = 1, z = 2)
    assign item.origin  = {i_origin_z, i_origin_y, i_origin_x};
    assign item.dir     = {i_dir_z, i_dir_y, i_dir_x};
    assign item.box_min = {i_box_min_z, i_box_min_y, i_box_min_x};
    assign item.box_max = {i_box_max_z, i_box_max_y, i_box_max_x};

    // front: differences, scaled direction, zero-direction inside test
    rbs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (item),
        .o_full     (full),
        .i_req_full (req_full),
        .o_req_push (fr_push),
        .o_req      (fr_req)
    );

    // short queue so the front keeps taking items while the back stalls
    rbs_req_queue u_req_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_push),
        .i_data  (fr_req),
        .o_full  (req_full),
        .i_pop   (req_pop),
        .o_empty (req_empty),
        .o_data  (q_req)
    );

    // back: dividers, ordering and the three clip stages
    rbs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (!req_empty),
        .i_req       (q_req),
        .o_req_pop   (req_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (bk_res)
    );

    // results wait here until popped
    rbs_res_queue u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (bk_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (out_res)
    );

    assign o_hit         = out_res.hit;
    assign o_enter_param = out_res.enter_param;

    // a miss never carries an entry parameter
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_hit) |-> (o_enter_param == '0))
        else $error("miss result with nonzero entry parameter");

    // the entry parameter never exceeds one
    a_enter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_enter_param <= rbs_pkg::ENTER_W'(65536)))
        else $error("entry parameter above one");

    // reset leaves no result waiting
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

endmodule

@@ hdl/rbs_front.sv @@
// ----------------------------------------------------------------------------
// rbs_front
// accepts items and forms slab numerators, scaled denominators and flags
// ----------------------------------------------------------------------------
module rbs_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rbs_pkg::t_ray_in   i_item,
    output logic               o_full,
    input  logic               i_req_full,
    output logic               o_req_push,
    output rbs_pkg::t_slab_req o_req
);

    logic                      r_fv;
    rbs_pkg::t_slab_req        r_req;
    rbs_pkg::t_slab_req        n_req;
    logic                      free;

    logic signed [rbs_pkg::NUM_W-1:0] v_org [rbs_pkg::AXES];
    logic signed [rbs_pkg::NUM_W-1:0] v_lo  [rbs_pkg::AXES];
    logic signed [rbs_pkg::NUM_W-1:0] v_hi  [rbs_pkg::AXES];
    logic signed [rbs_pkg::DEN_W-1:0] v_dir [rbs_pkg::AXES];

    assign free       = !r_fv || !i_req_full;
    assign o_full     = !free;
    assign o_req_push = r_fv && !i_req_full;
    assign o_req      = r_req;

    always_comb begin
        n_req = '0;
        for (int a = 0; a < rbs_pkg::AXES; a++) begin
            v_org[a] = rbs_pkg::NUM_W'(i_item.origin[a]);
            v_lo[a]  = rbs_pkg::NUM_W'(i_item.box_min[a]);
            v_hi[a]  = rbs_pkg::NUM_W'(i_item.box_max[a]);
            v_dir[a] = rbs_pkg::DEN_W'(i_item.dir[a]);
            n_req.num_lo[a] = v_lo[a] - v_org[a];
            n_req.num_hi[a] = v_hi[a] - v_org[a];
            n_req.den[a]    = v_dir[a] * rbs_pkg::DEN_W'(rbs_pkg::SEG_SCALE);
            n_req.zero[a]   = (i_item.dir[a] == '0);
            n_req.org_in[a] = !((v_org[a] < v_lo[a]) || (v_org[a] > v_hi[a]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (free) begin
            r_fv <= i_push;
        end
        if (free && i_push) begin
            r_req <= n_req;
        end
    end

endmodule

@@ hdl/rbs_req_queue.sv @@
// ----------------------------------------------------------------------------
// rbs_req_queue
// short queue between the front and the divider pipeline
// ----------------------------------------------------------------------------
module rbs_req_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rbs_pkg::t_slab_req i_data,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output rbs_pkg::t_slab_req o_data
);

    rbs_pkg::t_slab_req               r_mem [rbs_pkg::REQ_DEPTH];
    logic [rbs_pkg::REQ_PTR_W-1:0]    r_wr;
    logic [rbs_pkg::REQ_PTR_W-1:0]    r_rd;
    logic [rbs_pkg::REQ_CNT_W-1:0]    r_cnt;
    logic                             wr_en;
    logic                             rd_en;

    assign o_full  = (r_cnt == rbs_pkg::REQ_CNT_W'(rbs_pkg::REQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) r_wr <= r_wr + 1'b1;
            if (rd_en) r_rd <= r_rd + 1'b1;
            if (wr_en && !rd_en) r_cnt <= r_cnt + 1'b1;
            else if (rd_en && !wr_en) r_cnt <= r_cnt - 1'b1;
        end
        if (wr_en) r_mem[r_wr] <= i_data;
    end

endmodule

@@ hdl/rbs_back.sv @@
// ----------------------------------------------------------------------------
// rbs_back
// pipelined slab dividers, sign and ordering, then clipping axis by axis
// ----------------------------------------------------------------------------
module rbs_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  rbs_pkg::t_slab_req i_req,
    output logic               o_req_pop,
    input  logic               i_res_full,
    output logic               o_res_push,
    output rbs_pkg::t_result   o_res
);

    localparam int NS   = rbs_pkg::DIV_STEPS;
    localparam int LAST = NS + 4;

    logic [LAST:0] r_vld;
    logic          adv;

    // divider stages: 0 is the prepared operand, 1..NS one quotient bit each
    logic [rbs_pkg::R_W-1:0]   r_rem  [NS+1][rbs_pkg::LANES];
    logic [rbs_pkg::Q_W-1:0]   r_quo  [NS+1][rbs_pkg::LANES];
    logic                      r_sat  [NS+1][rbs_pkg::LANES];
    logic                      r_neg  [NS+1][rbs_pkg::LANES];
    logic [rbs_pkg::DEN_W-1:0] r_dmag [NS+1][rbs_pkg::AXES];
    logic                      r_zero [NS+1][rbs_pkg::AXES];
    logic                      r_ins  [NS+1][rbs_pkg::AXES];

    // clip stages: 0 after sign and ordering, 1..3 after each axis
    logic signed [rbs_pkg::T_W-1:0] r_ta   [4][rbs_pkg::AXES];
    logic signed [rbs_pkg::T_W-1:0] r_tb   [4][rbs_pkg::AXES];
    logic                           r_zc   [4][rbs_pkg::AXES];
    logic                           r_ic   [4][rbs_pkg::AXES];
    logic signed [rbs_pkg::T_W-1:0] r_tin  [4];
    logic signed [rbs_pkg::T_W-1:0] r_tout [4];
    logic                           r_hit  [4];

    logic [rbs_pkg::R_W-1:0]        n_rem0  [rbs_pkg::LANES];
    logic                           n_sat0  [rbs_pkg::LANES];
    logic                           n_neg0  [rbs_pkg::LANES];
    logic [rbs_pkg::DEN_W-1:0]      n_dmag0 [rbs_pkg::AXES];
    logic signed [rbs_pkg::NUM_W-1:0] v_num [rbs_pkg::LANES];
    logic [rbs_pkg::NUM_W-1:0]      v_nmag  [rbs_pkg::LANES];
    logic [rbs_pkg::R_W:0]          v_step  [NS][rbs_pkg::LANES];

    logic signed [rbs_pkg::T_W-1:0] v_tmag [rbs_pkg::LANES];
    logic signed [rbs_pkg::T_W-1:0] v_t    [rbs_pkg::LANES];
    logic signed [rbs_pkg::T_W-1:0] n_ta   [rbs_pkg::AXES];
    logic signed [rbs_pkg::T_W-1:0] n_tb   [rbs_pkg::AXES];

    logic signed [rbs_pkg::T_W-1:0] n_tin  [1:3];
    logic signed [rbs_pkg::T_W-1:0] n_tout [1:3];
    logic                           n_hit  [1:3];

    function automatic logic [rbs_pkg::R_W:0] div_step(
        input logic [rbs_pkg::R_W-1:0]   rem,
        input logic [rbs_pkg::DEN_W-1:0] dmag
    );
        logic [rbs_pkg::R_W-1:0] d2;
        logic [rbs_pkg::R_W-1:0] r2;
        logic                    ge;
        d2 = {1'b0, dmag, 1'b0};
        ge = (rem >= d2);
        r2 = ge ? rem - d2 : rem;
        return {ge, r2[rbs_pkg::R_W-2:0], 1'b0};
    endfunction

    assign adv        = !(r_vld[LAST] && i_res_full);
    assign o_req_pop  = adv && i_req_valid;
    assign o_res_push = r_vld[LAST] && !i_res_full;

    // operand preparation: magnitudes, sign of the quotient, saturation test
    always_comb begin
        for (int a = 0; a < rbs_pkg::AXES; a++) begin
            n_dmag0[a] = i_req.den[a][rbs_pkg::DEN_W-1] ? -i_req.den[a] : i_req.den[a];
            for (int s = 0; s < 2; s++) begin
                v_num[2*a+s]  = (s == 0) ? i_req.num_lo[a] : i_req.num_hi[a];
                v_nmag[2*a+s] = v_num[2*a+s][rbs_pkg::NUM_W-1] ? -v_num[2*a+s]
                                                               : v_num[2*a+s];
                n_neg0[2*a+s] = v_num[2*a+s][rbs_pkg::NUM_W-1]
                              ^ i_req.den[a][rbs_pkg::DEN_W-1];
                n_rem0[2*a+s] = rbs_pkg::R_W'(v_nmag[2*a+s]);
                n_sat0[2*a+s] = (rbs_pkg::R_W'(v_nmag[2*a+s]) >= {n_dmag0[a], 2'b00});
            end
        end
    end

    // one restoring step per divider stage
    always_comb begin
        for (int s = 0; s < NS; s++) begin
            for (int l = 0; l < rbs_pkg::LANES; l++) begin
                v_step[s][l] = div_step(r_rem[s][l], r_dmag[s][l/2]);
            end
        end
    end

    // signed slab parameters, ordered so that a <= b
    always_comb begin
        for (int l = 0; l < rbs_pkg::LANES; l++) begin
            v_tmag[l] = r_sat[NS][l] ? rbs_pkg::T_SAT : rbs_pkg::T_W'(r_quo[NS][l]);
            v_t[l]    = r_neg[NS][l] ? -v_tmag[l] : v_tmag[l];
        end
        for (int a = 0; a < rbs_pkg::AXES; a++) begin
            if (v_t[2*a] > v_t[2*a+1]) begin
                n_ta[a] = v_t[2*a+1];
                n_tb[a] = v_t[2*a];
            end else begin
                n_ta[a] = v_t[2*a];
                n_tb[a] = v_t[2*a+1];
            end
        end
    end

    // clipping, one axis per stage
    always_comb begin
        for (int k = 1; k <= 3; k++) begin
            n_tin[k]  = r_tin[k-1];
            n_tout[k] = r_tout[k-1];
            n_hit[k]  = r_hit[k-1];
            if (r_hit[k-1]) begin
                if (r_zc[k-1][k-1]) begin
                    n_hit[k] = r_ic[k-1][k-1];
                end else if ((r_tin[k-1] > r_tb[k-1][k-1]) ||
                             (r_ta[k-1][k-1] > r_tout[k-1])) begin
                    n_hit[k] = 1'b0;
                end else begin
                    if (r_ta[k-1][k-1] > r_tin[k-1]) n_tin[k] = r_ta[k-1][k-1];
                    if (r_tb[k-1][k-1] < r_tout[k-1]) n_tout[k] = r_tb[k-1][k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[LAST-1:0], i_req_valid};
        end
        if (adv) begin
            for (int l = 0; l < rbs_pkg::LANES; l++) begin
                r_rem[0][l] <= n_rem0[l];
                r_quo[0][l] <= '0;
                r_sat[0][l] <= n_sat0[l];
                r_neg[0][l] <= n_neg0[l];
            end
            for (int a = 0; a < rbs_pkg::AXES; a++) begin
                r_dmag[0][a] <= n_dmag0[a];
                r_zero[0][a] <= i_req.zero[a];
                r_ins[0][a]  <= i_req.org_in[a];
            end
            for (int s = 1; s <= NS; s++) begin
                for (int l = 0; l < rbs_pkg::LANES; l++) begin
                    r_rem[s][l] <= v_step[s-1][l][rbs_pkg::R_W-1:0];
                    r_quo[s][l] <= {r_quo[s-1][l][rbs_pkg::Q_W-2:0],
                                    v_step[s-1][l][rbs_pkg::R_W]};
                    r_sat[s][l] <= r_sat[s-1][l];
                    r_neg[s][l] <= r_neg[s-1][l];
                end
                for (int a = 0; a < rbs_pkg::AXES; a++) begin
                    r_dmag[s][a] <= r_dmag[s-1][a];
                    r_zero[s][a] <= r_zero[s-1][a];
                    r_ins[s][a]  <= r_ins[s-1][a];
                end
            end
            for (int a = 0; a < rbs_pkg::AXES; a++) begin
                r_ta[0][a] <= n_ta[a];
                r_tb[0][a] <= n_tb[a];
                r_zc[0][a] <= r_zero[NS][a];
                r_ic[0][a] <= r_ins[NS][a];
            end
            r_tin[0]  <= rbs_pkg::T_ZERO;
            r_tout[0] <= rbs_pkg::T_ONE;
            r_hit[0]  <= 1'b1;
            for (int k = 1; k <= 3; k++) begin
                for (int a = 0; a < rbs_pkg::AXES; a++) begin
                    r_ta[k][a] <= r_ta[k-1][a];
                    r_tb[k][a] <= r_tb[k-1][a];
                    r_zc[k][a] <= r_zc[k-1][a];
                    r_ic[k][a] <= r_ic[k-1][a];
                end
                r_tin[k]  <= n_tin[k];
                r_tout[k] <= n_tout[k];
                r_hit[k]  <= n_hit[k];
            end
        end
    end

    assign o_res.hit         = r_hit[3];
    assign o_res.enter_param = r_hit[3] ? r_tin[3][rbs_pkg::T_FRAC -: rbs_pkg::ENTER_W]
                                        : '0;

endmodule

@@ hdl/rbs_res_queue.sv @@
// ----------------------------------------------------------------------------
// rbs_res_queue
// result queue that faces the consumer
// ----------------------------------------------------------------------------
module rbs_res_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rbs_pkg::t_result i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output rbs_pkg::t_result o_data
);

    rbs_pkg::t_result              r_mem [rbs_pkg::RES_DEPTH];
    logic [rbs_pkg::RES_PTR_W-1:0] r_wr;
    logic [rbs_pkg::RES_PTR_W-1:0] r_rd;
    logic [rbs_pkg::RES_CNT_W-1:0] r_cnt;
    logic                          wr_en;
    logic                          rd_en;

    assign o_full  = (r_cnt == rbs_pkg::RES_CNT_W'(rbs_pkg::RES_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) r_wr <= r_wr + 1'b1;
            if (rd_en) r_rd <= r_rd + 1'b1;
            if (wr_en && !rd_en) r_cnt <= r_cnt + 1'b1;
            else if (rd_en && !wr_en) r_cnt <= r_cnt - 1'b1;
        end
        if (wr_en) r_mem[r_wr] <= i_data;
    end

endmodule

@@ tb/tb_ray_box_slab_intersect.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ray_box_slab_intersect
// checks segment / box slab tests against a local predictor
// ----------------------------------------------------------------------------
// A directed table covers the field extremes, zero directions, inverted boxes,
// grazing hits and the full-segment hit, followed by random rays built mostly
// around the box so that all three slabs get exercised. Both sides stall at
// random and results are compared in order with the predicted hit and entry.
// ----------------------------------------------------------------------------
module tb_ray_box_slab_intersect;

    localparam int CLK_PERIOD = 10;
    localparam int RANDOM_ITEMS = 530;
    localparam int DRAIN_CYCLES = 80;
    localparam longint CYCLE_LIMIT = 200000;
    localparam logic signed [63:0] PARAM_ONE = 64'sd1 <<< 32;
    localparam logic signed [63:0] PARAM_SAT = 64'sd4 <<< 32;

    typedef logic signed [31:0] t_coord;

    // one test: origin, dir, box_min, box_max, each x y z
    typedef struct {
        t_coord c[12];
    } t_ray_item;

    typedef struct {
        logic        hit;
        logic [16:0] enter;
    } t_hit_result;

    // directed row: stimulus plus an optional typed-in result
    typedef struct {
        t_ray_item   ray;
        bit          known;
        t_hit_result res;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    t_coord      coords[12];
    logic        empty;
    logic        pop;
    logic        o_hit;
    logic [16:0] o_enter_param;

    t_hit_result expected_hits[$];
    int          fail_count;
    longint      cycle_count;

    ray_box_slab_intersect dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_origin_x    (coords[0]),
        .i_origin_y    (coords[1]),
        .i_origin_z    (coords[2]),
        .i_dir_x       (coords[3]),
        .i_dir_y       (coords[4]),
        .i_dir_z       (coords[5]),
        .i_box_min_x   (coords[6]),
        .i_box_min_y   (coords[7]),
        .i_box_min_z   (coords[8]),
        .i_box_max_x   (coords[9]),
        .i_box_max_y   (coords[10]),
        .i_box_max_z   (coords[11]),
        .empty         (empty),
        .pop           (pop),
        .o_hit         (o_hit),
        .o_enter_param (o_enter_param)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // signed num / den, truncated magnitude, saturated at 4.0
    function automatic logic signed [63:0] slab_ratio(logic signed [63:0] num,
                                                      logic signed [63:0] den);
        logic [63:0]  n;
        logic [63:0]  d;
        logic [127:0] wide;
        logic [63:0]  q;
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        if (n / d >= 4) begin
            q = PARAM_SAT;
        end else begin
            wide = {64'd0, n} << 32;
            q = 64'(wide / {64'd0, d});
        end
        return ((num < 0) != (den < 0)) ? -$signed(q) : $signed(q);
    endfunction

    function automatic t_hit_result predict_hit(t_ray_item r);
        t_hit_result        res;
        logic signed [63:0] t_in;
        logic signed [63:0] t_out;
        logic signed [63:0] org, dir, lo, hi, a, b, s;
        bit                 ok;
        t_in = 0;
        t_out = PARAM_ONE;
        ok = 1'b1;
        for (int ax = 0; ax < 3 && ok; ax++) begin
            org = r.c[ax];
            dir = r.c[3 + ax];
            lo = r.c[6 + ax];
            hi = r.c[9 + ax];
            if (dir == 0) begin
                ok = !(org < lo || org > hi);
            end else begin
                a = slab_ratio(lo - org, dir * 1000);
                b = slab_ratio(hi - org, dir * 1000);
                if (a > b) begin
                    s = a;
                    a = b;
                    b = s;
                end
                if (t_in > b || a > t_out) begin
                    ok = 1'b0;
                end else begin
                    if (a > t_in) t_in = a;
                    if (b < t_out) t_out = b;
                end
            end
        end
        res.hit = ok;
        res.enter = ok ? t_in[32:16] : 17'd0;
        return res;
    endfunction

    function automatic t_ray_item make_ray(t_coord ox, t_coord oy, t_coord oz,
                                           t_coord dx, t_coord dy, t_coord dz,
                                           t_coord lx, t_coord ly, t_coord lz,
                                           t_coord hx, t_coord hy, t_coord hz);
        t_ray_item r;
        r.c = '{ox, oy, oz, dx, dy, dz, lx, ly, lz, hx, hy, hz};
        return r;
    endfunction

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            2: return 0;
            default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        endcase
    endfunction

    // mostly rays aimed at a box near them, rest pure noise
    function automatic t_ray_item rand_ray();
        t_ray_item r;
        t_coord lo, hi, s;
        if ($urandom_range(0, 9) < 2) begin
            foreach (r.c[i]) r.c[i] = rand_coord();
            return r;
        end
        for (int ax = 0; ax < 3; ax++) begin
            lo = $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
            hi = lo + $signed($urandom_range(0, 32'h0080_0000));
            if ($urandom_range(0, 19) == 0) begin
                s = lo;
                lo = hi;
                hi = s;
            end
            r.c[6 + ax] = lo;
            r.c[9 + ax] = hi;
            r.c[ax] = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
            // dir is roughly (target - origin) / 1000 times 1 to 3, with a target near the box
            r.c[3 + ax] = ($urandom_range(0, 7) == 0) ? 0 :
                          ((lo + $signed($urandom_range(0, 32'h0080_0000)) - r.c[ax])
                           / 1000) * $signed($urandom_range(1, 3));
        end
        return r;
    endfunction

    // present one item and wait until it is taken; push stays high afterwards
    task automatic send_ray(t_ray_item r, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        foreach (r.c[i]) coords[i] <= r.c[i];
        do @(posedge i_clk); while (full);
        expected_hits.push_back(predict_hit(r));
    endtask

    // result side: random wait after each item, compare with the oldest prediction
    initial begin
        t_hit_result want;
        int wait_cycles;
        pop = 1'b0;
        wait_cycles = 0;
        forever begin
            @(posedge i_clk);
            if (pop && !empty && i_rst_n) begin
                if (expected_hits.size() == 0) begin
                    $error("result item with nothing expected");
                    fail_count++;
                end else begin
                    want = expected_hits.pop_front();
                    if (o_hit !== want.hit) begin
                        $error("hit: expected %0d actual %0d", want.hit, o_hit);
                        fail_count++;
                    end
                    if (o_enter_param !== want.enter) begin
                        $error("enter_param: expected %0d actual %0d",
                               want.enter, o_enter_param);
                        fail_count++;
                    end
                end
                wait_cycles = $urandom_range(0, 3);
                if (cycle_count > 3000 && cycle_count < 3400) wait_cycles = 0;
            end
            if (wait_cycles > 0) begin
                pop <= 1'b0;
                wait_cycles--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        t_dir_row rows[$];
        t_dir_row row;
        t_hit_result got;
        localparam t_coord ONE = 32'sh0001_0000;
        localparam t_coord MAXC = 32'sh7fff_ffff;
        localparam t_coord MINC = 32'sh8000_0000;
        fail_count = 0;
        cycle_count = 0;
        push = 1'b0;
        foreach (coords[i]) coords[i] = '0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero direction, origin inside: hit at entry 0
        row.known = 1; row.res = '{1'b1, 17'd0};
        row.ray = make_ray(0, 0, 0, 0, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE);
        rows.push_back(row);
        // zero direction, origin on the bound: still a hit
        row.ray = make_ray(ONE, -ONE, ONE, 0, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE);
        rows.push_back(row);
        // zero direction, origin outside: miss
        row.res = '{1'b0, 17'd0};
        row.ray = make_ray(2 * ONE, 0, 0, 0, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE);
        rows.push_back(row);
        // inverted box with zero direction: miss
        row.ray = make_ray(0, 0, 0, 0, 0, 0, ONE, -ONE, -ONE, -ONE, ONE, ONE);
        rows.push_back(row);
        // box behind the origin: miss
        row.ray = make_ray(0, 0, 0, ONE, 0, 0, -3 * ONE, -ONE, -ONE, -2 * ONE, ONE, ONE);
        rows.push_back(row);
        // extreme coordinates, origin is the box corner
        row.res = '{1'b1, 17'd0};
        row.ray = make_ray(MINC, MINC, MINC, MAXC, MAXC, MAXC,
                           MINC, MINC, MINC, MAXC, MAXC, MAXC);
        rows.push_back(row);
        row.ray = make_ray(MAXC, MAXC, MAXC, MINC, MINC, MINC,
                           MINC, MINC, MINC, MAXC, MAXC, MAXC);
        rows.push_back(row);
        // the rest go through the predictor
        row.known = 0;
        row.ray = make_ray(0, 0, 0, 100, 0, 0, 50 * ONE, -ONE, -ONE, 60 * ONE, ONE, ONE);
        rows.push_back(row);
        row.ray = make_ray(0, 0, 0, ONE, ONE, ONE, 500 * ONE, 200 * ONE, 900 * ONE,
                           600 * ONE, 700 * ONE, 1100 * ONE);
        rows.push_back(row);
        // segment end exactly on the entry face
        row.ray = make_ray(0, 0, 0, ONE, 0, 0, 1000 * ONE, -ONE, -ONE,
                           1001 * ONE, ONE, ONE);
        rows.push_back(row);
        // negative direction, inverted box with nonzero direction
        row.ray = make_ray(10 * ONE, 0, 0, -ONE, 0, 0, 5 * ONE, -ONE, -ONE,
                           -5 * ONE, ONE, ONE);
        rows.push_back(row);
        row.ray = make_ray(MAXC, MINC, 0, MINC, MAXC, -1, MINC, MINC, MINC,
                           MAXC, MAXC, MAXC);
        rows.push_back(row);
        row.ray = make_ray(-1, -1, -1, -1, -1, -1, -2000, -2000, -2000, -1000, -1000, -1000);
        rows.push_back(row);
        row.ray = make_ray(0, 0, 0, 1, 1, 1, 1, 1, 1, MAXC, MAXC, MAXC);
        rows.push_back(row);
        row.ray = make_ray(0, 0, 0, ONE, -ONE, ONE, 10 * ONE, -900 * ONE, 20 * ONE,
                           800 * ONE, -10 * ONE, 30 * ONE);
        rows.push_back(row);

        foreach (rows[i]) begin
            if (rows[i].known) begin
                got = predict_hit(rows[i].ray);
                if (got.hit != rows[i].res.hit || got.enter != rows[i].res.enter) begin
                    $error("directed row %0d: table and predictor disagree", i);
                    fail_count++;
                end
            end
            send_ray(rows[i].ray, 1'b0);
        end

        // hold off until every pending result has drained
        push <= 1'b0;
        while (expected_hits.size() != 0) @(posedge i_clk);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // one stretch of back-to-back items, n from 200 to 259
            send_ray(rand_ray(), (n >= 200 && n < 260));
        end
        push <= 1'b0;

        while (expected_hits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/rbs_pkg.sv
hdl/rbs_front.sv
hdl/rbs_req_queue.sv
hdl/rbs_back.sv
hdl/rbs_res_queue.sv
hdl/ray_box_slab_intersect.sv
tb/tb_ray_box_slab_intersect.sv
